>>> src/gfr_pkg.sv
// Shared types and constants for the grid forward remap block with hole fill.
`default_nettype none

package gfr_pkg;

    // Operation codes carried by each input item.
    localparam logic [1:0] OP_SCATTER = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WEST_EDGE  = 3'd0;
    localparam logic [2:0] CFG_NORTH_EDGE = 3'd1;
    localparam logic [2:0] CFG_COLS_PER   = 3'd2;
    localparam logic [2:0] CFG_ROWS_PER   = 3'd3;
    localparam logic [2:0] CFG_GRID_COLS  = 3'd4;
    localparam logic [2:0] CFG_GRID_ROWS  = 3'd5;

    // Fixed field widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int LON_W      = 25;
    localparam int LAT_W      = 24;
    localparam int SCALE_W    = 24;
    localparam int GRID_W     = 10;
    localparam int RC_W       = 9;
    // Scaled offset: lon difference (26 bits) times Q10.14 scale, shifted right by 30.
    localparam int DIFF_W     = 26;
    localparam int PROD_W     = DIFF_W + SCALE_W;
    localparam int FRAC_SHIFT = 30;
    localparam int Q_W        = PROD_W - FRAC_SHIFT;

    // Each cell stores an epoch tag; a cell is occupied when its tag matches the current epoch.
    localparam int EPOCH_W = 4;

    // Neighbor offsets: up, down, left, right.
    localparam logic signed [1:0] NB_DX [4] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1};
    localparam logic signed [1:0] NB_DY [4] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0};

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DEC,
        S_MUL_X,
        S_MUL_Y,
        S_WRITE,
        S_RD_CENTER,
        S_RD_CHECK,
        S_NB_ISSUE,
        S_NB_ACC,
        S_NB_DONE,
        S_DIV,
        S_DIV_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mul_x;
        logic mul_y;
        logic cell_wr;
        logic sweep_wr;
        logic epoch_inc;
        logic epoch_set;
        logic rd_center;
        logic nb_issue;
        logic nb_acc;
        logic div_start;
        logic div_step;
        logic res_zero;
        logic res_cell;
        logic res_avg;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       sample_valid;
        logic       scatter_ok;
        logic       read_ok;
        logic       center_occ;
        logic       nb_last;
        logic       cnt_zero;
        logic       div_last;
        logic       sweep_last;
        logic       epoch_max;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> src/gfr_ctrl.sv
// Controller state machine that sequences scatter, read with hole fill and clear.
`default_nettype none

module gfr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire gfr_pkg::t_sts i_sts,
    output gfr_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    gfr_pkg::t_state r_state;
    gfr_pkg::t_state n_state;

    // State register; reset starts with a sweep of the tag memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gfr_pkg::S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gfr_pkg::S_SWEEP: begin
                if (i_sts.sweep_last) n_state = gfr_pkg::S_IDLE;
            end
            gfr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = gfr_pkg::S_DEC;
            end
            gfr_pkg::S_DEC: begin
                case (i_sts.op)
                    gfr_pkg::OP_SCATTER: begin
                        n_state = i_sts.sample_valid ? gfr_pkg::S_MUL_X : gfr_pkg::S_IDLE;
                    end
                    gfr_pkg::OP_READ: n_state = gfr_pkg::S_RD_CENTER;
                    gfr_pkg::OP_CLEAR: begin
                        n_state = i_sts.epoch_max ? gfr_pkg::S_SWEEP : gfr_pkg::S_IDLE;
                    end
                    default: n_state = gfr_pkg::S_IDLE;
                endcase
            end
            gfr_pkg::S_MUL_X:     n_state = gfr_pkg::S_MUL_Y;
            gfr_pkg::S_MUL_Y:     n_state = gfr_pkg::S_WRITE;
            gfr_pkg::S_WRITE:     n_state = gfr_pkg::S_IDLE;
            gfr_pkg::S_RD_CENTER: n_state = gfr_pkg::S_RD_CHECK;
            gfr_pkg::S_RD_CHECK: begin
                if (!i_sts.read_ok || i_sts.center_occ) begin
                    n_state = gfr_pkg::S_OUT;
                end else begin
                    n_state = gfr_pkg::S_NB_ISSUE;
                end
            end
            gfr_pkg::S_NB_ISSUE: n_state = gfr_pkg::S_NB_ACC;
            gfr_pkg::S_NB_ACC: begin
                n_state = i_sts.nb_last ? gfr_pkg::S_NB_DONE : gfr_pkg::S_NB_ISSUE;
            end
            gfr_pkg::S_NB_DONE: begin
                n_state = i_sts.cnt_zero ? gfr_pkg::S_OUT : gfr_pkg::S_DIV;
            end
            gfr_pkg::S_DIV: begin
                if (i_sts.div_last) n_state = gfr_pkg::S_DIV_FIN;
            end
            gfr_pkg::S_DIV_FIN: n_state = gfr_pkg::S_OUT;
            gfr_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = gfr_pkg::S_IDLE;
            end
            default: n_state = gfr_pkg::S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            gfr_pkg::S_SWEEP: begin
                o_cmd.sweep_wr  = 1'b1;
                o_cmd.epoch_set = i_sts.sweep_last;
            end
            gfr_pkg::S_IDLE: o_cmd.load_in = i_in_valid;
            gfr_pkg::S_DEC: begin
                o_cmd.epoch_inc = (i_sts.op == gfr_pkg::OP_CLEAR) && !i_sts.epoch_max;
            end
            gfr_pkg::S_MUL_X:     o_cmd.mul_x = 1'b1;
            gfr_pkg::S_MUL_Y:     o_cmd.mul_y = 1'b1;
            gfr_pkg::S_WRITE:     o_cmd.cell_wr = i_sts.scatter_ok;
            gfr_pkg::S_RD_CENTER: o_cmd.rd_center = 1'b1;
            gfr_pkg::S_RD_CHECK: begin
                o_cmd.res_zero = !i_sts.read_ok;
                o_cmd.res_cell = i_sts.read_ok && i_sts.center_occ;
            end
            gfr_pkg::S_NB_ISSUE: o_cmd.nb_issue = 1'b1;
            gfr_pkg::S_NB_ACC:   o_cmd.nb_acc = 1'b1;
            gfr_pkg::S_NB_DONE: begin
                o_cmd.res_zero  = i_sts.cnt_zero;
                o_cmd.div_start = !i_sts.cnt_zero;
            end
            gfr_pkg::S_DIV:     o_cmd.div_step = 1'b1;
            gfr_pkg::S_DIV_FIN: o_cmd.res_avg = 1'b1;
            gfr_pkg::S_OUT:     o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != gfr_pkg::S_IDLE);

endmodule

`default_nettype wire

>>> src/gfr_datapath.sv
// Datapath: configuration registers, offset scaling, cell memory, neighbor sum and divider.
`default_nettype none

module gfr_datapath #(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [gfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [gfr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic [1:0]                          i_operation,
    input  wire logic signed [gfr_pkg::LON_W-1:0]    i_sample_lon,
    input  wire logic signed [gfr_pkg::LAT_W-1:0]    i_sample_lat,
    input  wire logic signed [VALUE_BITS-1:0]        i_sample_value,
    input  wire logic                                i_sample_valid,
    input  wire logic [gfr_pkg::RC_W-1:0]            i_read_column,
    input  wire logic [gfr_pkg::RC_W-1:0]            i_read_row,
    input  wire logic                                i_out_stall,
    input  wire gfr_pkg::t_cmd                       i_cmd,
    output gfr_pkg::t_sts                            o_sts,
    output logic                                     o_out_valid,
    output logic signed [VALUE_BITS-1:0]             o_cell_value,
    output logic                                     o_cell_has_data,
    output logic                                     o_cell_was_filled
);

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int DEPTH   = MAX_ROWS * (2 ** COL_W);
    localparam int LIM_C   = $clog2(MAX_COLUMNS + 1);
    localparam int LIM_R   = $clog2(MAX_ROWS + 1);
    localparam int LIM_M   = (LIM_C > LIM_R) ? LIM_C : LIM_R;
    localparam int LIM_W   = (LIM_M > gfr_pkg::GRID_W) ? LIM_M : gfr_pkg::GRID_W;
    localparam int CMP_W   = ((gfr_pkg::Q_W > LIM_W) ? gfr_pkg::Q_W : LIM_W) + 1;
    localparam int NB_W    = LIM_W + 2;
    localparam int SUM_W   = VALUE_BITS + 2;
    localparam int MAG_W   = VALUE_BITS + 2;
    localparam int DCNT_W  = $clog2(MAG_W + 1);
    localparam int WORD_W  = gfr_pkg::EPOCH_W + VALUE_BITS;

    // Configuration registers.
    logic signed [gfr_pkg::LON_W-1:0]   r_west;
    logic signed [gfr_pkg::LAT_W-1:0]   r_north;
    logic [gfr_pkg::SCALE_W-1:0]        r_cols_per;
    logic [gfr_pkg::SCALE_W-1:0]        r_rows_per;
    logic [gfr_pkg::GRID_W-1:0]         r_grid_cols;
    logic [gfr_pkg::GRID_W-1:0]         r_grid_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_west      <= '0;
            r_north     <= '0;
            r_cols_per  <= '0;
            r_rows_per  <= '0;
            r_grid_cols <= gfr_pkg::GRID_W'(512);
            r_grid_rows <= gfr_pkg::GRID_W'(512);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gfr_pkg::CFG_WEST_EDGE:  r_west      <= i_cfg_data[gfr_pkg::LON_W-1:0];
                gfr_pkg::CFG_NORTH_EDGE: r_north     <= i_cfg_data[gfr_pkg::LAT_W-1:0];
                gfr_pkg::CFG_COLS_PER:   r_cols_per  <= i_cfg_data[gfr_pkg::SCALE_W-1:0];
                gfr_pkg::CFG_ROWS_PER:   r_rows_per  <= i_cfg_data[gfr_pkg::SCALE_W-1:0];
                gfr_pkg::CFG_GRID_COLS:  r_grid_cols <= i_cfg_data[gfr_pkg::GRID_W-1:0];
                gfr_pkg::CFG_GRID_ROWS:  r_grid_rows <= i_cfg_data[gfr_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid size in use, clamped to the memory size.
    logic [LIM_W-1:0] cols_eff;
    logic [LIM_W-1:0] rows_eff;
    assign cols_eff = (LIM_W'(r_grid_cols) > LIM_W'(MAX_COLUMNS)) ? LIM_W'(MAX_COLUMNS)
                                                                : LIM_W'(r_grid_cols);
    assign rows_eff = (LIM_W'(r_grid_rows) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                             : LIM_W'(r_grid_rows);

    // Input item registers; the coordinate offsets are formed on capture.
    logic [1:0]                          r_op;
    logic                                r_valid_in;
    logic signed [gfr_pkg::DIFF_W-1:0]   r_dx;
    logic signed [gfr_pkg::DIFF_W-1:0]   r_dy;
    logic signed [VALUE_BITS-1:0]        r_value;
    logic [gfr_pkg::RC_W-1:0]            r_rcol;
    logic [gfr_pkg::RC_W-1:0]            r_rrow;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op       <= i_operation;
            r_valid_in <= i_sample_valid;
            r_dx       <= gfr_pkg::DIFF_W'(i_sample_lon) - gfr_pkg::DIFF_W'(r_west);
            r_dy       <= gfr_pkg::DIFF_W'(r_north) - gfr_pkg::DIFF_W'(i_sample_lat);
            r_value    <= i_sample_value;
            r_rcol     <= i_read_column;
            r_rrow     <= i_read_row;
        end
    end

    // One shared multiplier scales the column offset, then the row offset.
    logic [gfr_pkg::DIFF_W-1:0]  dx_mag;
    logic [gfr_pkg::DIFF_W-1:0]  dy_mag;
    logic [gfr_pkg::DIFF_W-1:0]  mul_a;
    logic [gfr_pkg::SCALE_W-1:0] mul_b;
    logic [gfr_pkg::PROD_W-1:0]  prod;
    logic [gfr_pkg::Q_W-1:0]     r_qx;
    logic [gfr_pkg::Q_W-1:0]     r_qy;
    logic                        r_xneg;
    logic                        r_yneg;

    assign dx_mag = r_dx[gfr_pkg::DIFF_W-1] ? (-r_dx) : r_dx;
    assign dy_mag = r_dy[gfr_pkg::DIFF_W-1] ? (-r_dy) : r_dy;
    assign mul_a  = i_cmd.mul_y ? dy_mag : dx_mag;
    assign mul_b  = i_cmd.mul_y ? r_rows_per : r_cols_per;
    assign prod   = gfr_pkg::PROD_W'(mul_a) * gfr_pkg::PROD_W'(mul_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_x) begin
            r_qx   <= prod[gfr_pkg::PROD_W-1:gfr_pkg::FRAC_SHIFT];
            r_xneg <= r_dx[gfr_pkg::DIFF_W-1];
        end
        if (i_cmd.mul_y) begin
            r_qy   <= prod[gfr_pkg::PROD_W-1:gfr_pkg::FRAC_SHIFT];
            r_yneg <= r_dy[gfr_pkg::DIFF_W-1];
        end
    end

    // A negative offset that truncates to zero still lands in column or row zero.
    logic x_in;
    logic y_in;
    assign x_in = (!r_xneg || (r_qx == '0)) && (CMP_W'(r_qx) < CMP_W'(cols_eff));
    assign y_in = (!r_yneg || (r_qy == '0)) && (CMP_W'(r_qy) < CMP_W'(rows_eff));

    // Read coordinates and neighbor addressing.
    logic [LIM_W-1:0]        xe;
    logic [LIM_W-1:0]        ye;
    logic [1:0]              r_k;
    logic signed [NB_W-1:0]  nx;
    logic signed [NB_W-1:0]  ny;
    logic                    nb_ok;
    logic                    read_ok;

    assign xe      = LIM_W'(r_rcol);
    assign ye      = LIM_W'(r_rrow);
    assign read_ok = (xe < cols_eff) && (ye < rows_eff);
    assign nx      = $signed({2'b00, xe}) + NB_W'(gfr_pkg::NB_DX[r_k]);
    assign ny      = $signed({2'b00, ye}) + NB_W'(gfr_pkg::NB_DY[r_k]);
    assign nb_ok   = (nx >= 0) && (nx < $signed({2'b00, cols_eff}))
                  && (ny >= 0) && (ny < $signed({2'b00, rows_eff}));

    // Sweep counter and epoch.
    logic [ADDR_W-1:0]           r_sw;
    logic                        sweep_last;
    logic [gfr_pkg::EPOCH_W-1:0] r_epoch;

    assign sweep_last = (r_sw == ADDR_W'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw    <= '0;
            r_epoch <= gfr_pkg::EPOCH_W'(1);
        end else begin
            if (i_cmd.sweep_wr) begin
                r_sw <= sweep_last ? '0 : r_sw + 1'b1;
            end
            if (i_cmd.epoch_set) begin
                r_epoch <= gfr_pkg::EPOCH_W'(1);
            end else if (i_cmd.epoch_inc) begin
                r_epoch <= r_epoch + 1'b1;
            end
        end
    end

    // Cell memory: epoch tag over value, one write and one registered read per cycle.
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rd;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic [ADDR_W-1:0] mem_ra;
    logic              mem_re;

    assign mem_we = i_cmd.sweep_wr || i_cmd.cell_wr;
    assign mem_wa = i_cmd.sweep_wr ? r_sw : {r_qy[ROW_W-1:0], r_qx[COL_W-1:0]};
    assign mem_wd = i_cmd.sweep_wr ? WORD_W'(0) : {r_epoch, r_value};
    assign mem_re = i_cmd.rd_center || i_cmd.nb_issue;
    assign mem_ra = i_cmd.rd_center ? {ye[ROW_W-1:0], xe[COL_W-1:0]}
                                    : {ny[ROW_W-1:0], nx[COL_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    logic                         occ;
    logic signed [VALUE_BITS-1:0] rd_value;
    assign occ      = (r_rd[WORD_W-1:VALUE_BITS] == r_epoch);
    assign rd_value = r_rd[VALUE_BITS-1:0];

    // Neighbor accumulation.
    logic                    r_nbok;
    logic signed [SUM_W-1:0] r_sum;
    logic [2:0]              r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_center) begin
            r_k   <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.nb_issue) begin
            r_nbok <= nb_ok;
        end
        if (i_cmd.nb_acc) begin
            r_k <= r_k + 1'b1;
            if (r_nbok && occ) begin
                r_sum <= r_sum + SUM_W'(rd_value);
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle, magnitude over neighbor count.
    logic              r_dneg;
    logic [MAG_W-1:0]  r_dq;
    logic [1:0]        r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic [2:0]        trial;
    logic              qbit;
    logic [MAG_W-1:0]  sum_mag;
    logic [MAG_W-1:0]  avg_full;

    assign sum_mag  = r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);
    assign trial    = {r_rem, r_dq[MAG_W-1]};
    assign qbit     = (trial >= r_cnt);
    assign avg_full = r_dneg ? (-r_dq) : r_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= DCNT_W'(MAG_W);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dneg <= r_sum[SUM_W-1];
            r_dq   <= sum_mag;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[MAG_W-2:0], qbit};
            r_rem <= qbit ? 2'(trial - r_cnt) : trial[1:0];
        end
    end

    // Result holding register and output register.
    logic signed [VALUE_BITS-1:0] r_res_value;
    logic                         r_res_has;
    logic                         r_res_filled;
    logic                         r_out_valid;
    logic                         out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res_value  <= '0;
            r_res_has    <= 1'b0;
            r_res_filled <= 1'b0;
        end else if (i_cmd.res_cell) begin
            r_res_value  <= rd_value;
            r_res_has    <= 1'b1;
            r_res_filled <= 1'b0;
        end else if (i_cmd.res_avg) begin
            r_res_value  <= avg_full[VALUE_BITS-1:0];
            r_res_has    <= 1'b1;
            r_res_filled <= 1'b1;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_cell_value      <= r_res_value;
            o_cell_has_data   <= r_res_has;
            o_cell_was_filled <= r_res_filled;
        end
    end

    assign o_out_valid = r_out_valid;

    // Status back to the controller.
    always_comb begin
        o_sts              = '0;
        o_sts.op           = r_op;
        o_sts.sample_valid = r_valid_in;
        o_sts.scatter_ok   = x_in && y_in;
        o_sts.read_ok      = read_ok;
        o_sts.center_occ   = occ;
        o_sts.nb_last      = (r_k == 2'd3);
        o_sts.cnt_zero     = (r_cnt == '0);
        o_sts.div_last     = (r_dcnt == DCNT_W'(1));
        o_sts.sweep_last   = sweep_last;
        o_sts.epoch_max    = (r_epoch == '1);
        o_sts.out_free     = out_free;
    end

    // The divider only steps while bits remain.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_dcnt != '0))
        else $error("divider stepped with no bits left");

    // Epoch zero marks swept cells and is never current.
    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("current epoch is zero");

    // A new result only appears after a load from the result register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.out_load))
        else $error("output valid rose without a load");

endmodule

`default_nettype wire

>>> src/grid_forward_remap_hole_fill_top.sv
// Top level of the grid forward remap block with neighbor hole fill.
//
// Takes one item at a time. A scatter runs through capture, decode, two passes through
// the shared offset multiplier and a memory write. A read of an occupied or out-of-grid
// cell ends with its result in the output register. An empty cell adds the four neighbor
// reads through the single memory read port and the neighbor count check, and then
// the bit-serial divide by the neighbor count when any neighbor holds data. A clear
// advances an epoch tag; every 15th clear, and once after reset, the block instead
// sweeps the tag memory, while it accepts no item. Configuration writes are taken at
// any time.
`default_nettype none

module grid_forward_remap_hole_fill_top #(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [gfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gfr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [1:0]                       i_operation,
    input  wire logic signed [gfr_pkg::LON_W-1:0] i_sample_lon,
    input  wire logic signed [gfr_pkg::LAT_W-1:0] i_sample_lat,
    input  wire logic signed [VALUE_BITS-1:0]     i_sample_value,
    input  wire logic                             i_sample_valid,
    input  wire logic [gfr_pkg::RC_W-1:0]         i_read_column,
    input  wire logic [gfr_pkg::RC_W-1:0]         i_read_row,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [VALUE_BITS-1:0]          o_cell_value,
    output logic                                  o_cell_has_data,
    output logic                                  o_cell_was_filled
);

    gfr_pkg::t_cmd cmd;
    gfr_pkg::t_sts sts;

    // Sequencer.
    gfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Arithmetic, memory and output register.
    gfr_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_operation       (i_operation),
        .i_sample_lon      (i_sample_lon),
        .i_sample_lat      (i_sample_lat),
        .i_sample_value    (i_sample_value),
        .i_sample_valid    (i_sample_valid),
        .i_read_column     (i_read_column),
        .i_read_row        (i_read_row),
        .i_out_stall       (i_out_stall),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .o_cell_value      (o_cell_value),
        .o_cell_has_data   (o_cell_has_data),
        .o_cell_was_filled (o_cell_was_filled)
    );

endmodule

`default_nettype wire

>>> verif/grid_forward_remap_hole_fill_top_test.sv
// Self-checking testbench for the grid forward remap block with neighbor hole fill.
`default_nettype none

module grid_forward_remap_hole_fill_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS = 512;
    localparam int NROWS = 512;
    localparam int NCELLS = NCOLS * NROWS;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         op;
        logic signed [24:0] lon;
        logic signed [23:0] lat;
        logic signed [15:0] value;
        logic               valid;
        logic [8:0]         column;
        logic [8:0]         row;
    } t_sample_item;

    typedef struct {
        logic signed [15:0] value;
        logic               has_data;
        logic               was_filled;
    } t_cell_read;

    // Block ports.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [24:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_operation = gfr_pkg::OP_SCATTER;
    logic signed [24:0] i_sample_lon = '0;
    logic signed [23:0] i_sample_lat = '0;
    logic signed [15:0] i_sample_value = '0;
    logic               i_sample_valid = 1'b0;
    logic [8:0]         i_read_column = '0;
    logic [8:0]         i_read_row = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_cell_value;
    logic               o_cell_has_data;
    logic               o_cell_was_filled;

    grid_forward_remap_hole_fill_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_sample_lon(i_sample_lon),
        .i_sample_lat(i_sample_lat), .i_sample_value(i_sample_value),
        .i_sample_valid(i_sample_valid), .i_read_column(i_read_column),
        .i_read_row(i_read_row),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_cell_value(o_cell_value), .o_cell_has_data(o_cell_has_data),
        .o_cell_was_filled(o_cell_was_filled)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the grid and its settings.
    longint             west_deg, north_deg, col_scale, row_scale;
    int unsigned        cols_in_use, rows_in_use;
    logic signed [15:0] shadow_value [NCELLS];
    bit                 shadow_full [NCELLS];

    t_sample_item pending_items [$];
    t_cell_read   expected_reads [$];
    int           error_count = 0;
    bit           no_waits = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic longint offset_to_cell(input longint d, input longint s);
        longint mag;
        mag = (d < 0) ? -d : d;
        mag = (mag * s) >>> 30;
        return (d < 0) ? -mag : mag;
    endfunction

    // Apply one accepted item to the shadow grid; a read yields the expected cell.
    task automatic apply_sample(input t_sample_item it);
        longint     ix, iy, sum, count, nx, ny;
        int         cols, rows;
        int         dx [4];
        int         dy [4];
        t_cell_read res;
        dx = '{0, 0, -1, 1};
        dy = '{-1, 1, 0, 0};
        cols = (cols_in_use > NCOLS) ? NCOLS : int'(cols_in_use);
        rows = (rows_in_use > NROWS) ? NROWS : int'(rows_in_use);
        case (it.op)
            gfr_pkg::OP_SCATTER: begin
                if (it.valid) begin
                    ix = offset_to_cell(longint'(it.lon) - west_deg, col_scale);
                    iy = offset_to_cell(north_deg - longint'(it.lat), row_scale);
                    if (ix >= 0 && ix < cols && iy >= 0 && iy < rows) begin
                        shadow_value[iy * NCOLS + ix] = it.value;
                        shadow_full[iy * NCOLS + ix] = 1'b1;
                    end
                end
            end
            gfr_pkg::OP_CLEAR: begin
                foreach (shadow_full[k]) shadow_full[k] = 1'b0;
            end
            gfr_pkg::OP_READ: begin
                res = '{16'sd0, 1'b0, 1'b0};
                if (it.column < cols && it.row < rows) begin
                    if (shadow_full[it.row * NCOLS + it.column]) begin
                        res = '{shadow_value[it.row * NCOLS + it.column], 1'b1, 1'b0};
                    end else begin
                        sum = 0;
                        count = 0;
                        for (int k = 0; k < 4; k++) begin
                            nx = longint'(it.column) + dx[k];
                            ny = longint'(it.row) + dy[k];
                            if (nx >= 0 && nx < cols && ny >= 0 && ny < rows &&
                                shadow_full[ny * NCOLS + nx]) begin
                                sum += longint'(shadow_value[ny * NCOLS + nx]);
                                count++;
                            end
                        end
                        if (count > 0) res = '{16'(sum / count), 1'b1, 1'b1};
                    end
                end
                expected_reads.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic int draw_wait();
        return no_waits ? 0 : $urandom_range(0, 18);
    endfunction

    // Input side: track acceptance and feed the shadow grid.
    bit in_taken = 1'b0;
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken)
            apply_sample('{i_operation, i_sample_lon, i_sample_lat, i_sample_value,
                           i_sample_valid, i_read_column, i_read_row});
    end

    // Driver: presents queued items with random gaps between them.
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_sample_item it;
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_operation <= it.op;
                i_sample_lon <= it.lon;
                i_sample_lat <= it.lat;
                i_sample_value <= it.value;
                i_sample_valid <= it.valid;
                i_read_column <= it.column;
                i_read_row <= it.row;
                i_in_valid <= 1'b1;
                gap_left = draw_wait();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: random stall per result, check against the oldest expected read.
    bit out_taken = 1'b0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_cell_read exp_cell;
        out_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (out_taken) begin
            if (expected_reads.size() == 0) begin
                report_mismatch("result with no read outstanding");
            end else begin
                exp_cell = expected_reads.pop_front();
                if (o_cell_value !== exp_cell.value)
                    report_mismatch($sformatf("cell_value %0d, expected %0d",
                                              o_cell_value, exp_cell.value));
                if (o_cell_has_data !== exp_cell.has_data)
                    report_mismatch($sformatf("cell_has_data %b, expected %b",
                                              o_cell_has_data, exp_cell.has_data));
                if (o_cell_was_filled !== exp_cell.was_filled)
                    report_mismatch($sformatf("cell_was_filled %b, expected %b",
                                              o_cell_was_filled, exp_cell.was_filled));
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_taken) stall_left = draw_wait();
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Register write at the falling edge; the shadow settings follow.
    task automatic write_reg(input logic [2:0] index, input longint data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= 25'(data);
        case (index)
            gfr_pkg::CFG_WEST_EDGE:  west_deg = longint'($signed(25'(data)));
            gfr_pkg::CFG_NORTH_EDGE: north_deg = longint'($signed(24'(data)));
            gfr_pkg::CFG_COLS_PER:   col_scale = data & 64'hFFFFFF;
            gfr_pkg::CFG_ROWS_PER:   row_scale = data & 64'hFFFFFF;
            gfr_pkg::CFG_GRID_COLS:  cols_in_use = 32'(data & 64'h3FF);
            gfr_pkg::CFG_GRID_ROWS:  rows_in_use = 32'(data & 64'h3FF);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input longint w, input longint n, input longint cs,
                            input longint rs, input int c, input int r);
        write_reg(gfr_pkg::CFG_WEST_EDGE, w);
        write_reg(gfr_pkg::CFG_NORTH_EDGE, n);
        write_reg(gfr_pkg::CFG_COLS_PER, cs);
        write_reg(gfr_pkg::CFG_ROWS_PER, rs);
        write_reg(gfr_pkg::CFG_GRID_COLS, c);
        write_reg(gfr_pkg::CFG_GRID_ROWS, r);
    endtask

    // Wait until every queued item is taken and every read has returned.
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_reads.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic longint clamp(input longint v, input longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    // Scatter aimed at the center of cell (cx, cy) under the present settings.
    function automatic t_sample_item aimed_scatter(input int cx, input int cy,
                                                   input logic signed [15:0] v);
        t_sample_item it;
        longint lon, lat;
        lon = (col_scale == 0) ? west_deg :
              west_deg + (longint'(cx) * (64'sd1 << 30) + (64'sd1 << 29)) / col_scale;
        lat = (row_scale == 0) ? north_deg :
              north_deg - (longint'(cy) * (64'sd1 << 30) + (64'sd1 << 29)) / row_scale;
        it = '{gfr_pkg::OP_SCATTER, 25'(clamp(lon, 11796480)), 24'(clamp(lat, 5898240)), v,
               1'b1, 9'($urandom), 9'($urandom)};
        return it;
    endfunction

    function automatic t_sample_item read_at(input int cx, input int cy);
        t_sample_item it;
        it = '{gfr_pkg::OP_READ, 25'($urandom), 24'($urandom), 16'($urandom), 1'($urandom),
               9'(cx), 9'(cy)};
        return it;
    endfunction

    function automatic t_sample_item bare_op(input logic [1:0] op);
        t_sample_item it;
        it = read_at($urandom_range(0, 511), $urandom_range(0, 511));
        it.op = op;
        return it;
    endfunction

    // Column or row near the origin, near the far edge, or anywhere.
    function automatic int pick_coord(input int used);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $urandom_range(0, (used < 12 ? used : 12));
        if (sel < 9) return used - $urandom_range(0, 2) < 0 ? 0 :
                            (used - $urandom_range(0, 2) > 511 ? 511 : used - 1);
        return $urandom_range(0, 511);
    endfunction

    task automatic queue_random_items(input int n);
        t_sample_item it;
        int sel;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0) no_waits = !no_waits;
            sel = $urandom_range(0, 99);
            if (sel < 42) begin
                it = aimed_scatter(pick_coord(cols_in_use), pick_coord(rows_in_use),
                                   16'($urandom));
                it.lon = it.lon + 25'(int'($urandom_range(0, 6)) - 3);
            end else if (sel < 52) begin
                it = bare_op(gfr_pkg::OP_SCATTER);
                it.lon = 25'($urandom_range(0, 23592960)) - 25'sd11796480;
                it.lat = 24'($urandom_range(0, 11796480)) - 24'sd5898240;
                if ($urandom_range(0, 1)) it.valid = 1'b1;
            end else if (sel < 95) begin
                it = read_at(pick_coord(cols_in_use), pick_coord(rows_in_use));
            end else if (sel < 97) begin
                it = bare_op(gfr_pkg::OP_CLEAR);
            end else begin
                it = bare_op(OP_UNUSED);
            end
            pending_items.push_back(it);
        end
    endtask

    // Main sequence: reset, directed cases, then several grid settings.
    initial begin
        t_sample_item it;
        west_deg = 0;
        north_deg = 0;
        col_scale = 0;
        row_scale = 0;
        cols_in_use = 512;
        rows_in_use = 512;
        foreach (shadow_full[k]) shadow_full[k] = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero scale sends every valid sample to cell (0, 0).
        pending_items.push_back(read_at(0, 0));
        pending_items.push_back(read_at(511, 511));
        pending_items.push_back(aimed_scatter(0, 0, 16'sh7FFF));
        pending_items.push_back(read_at(0, 0));
        pending_items.push_back(read_at(1, 0));
        it = aimed_scatter(0, 0, -16'sh8000);
        it.valid = 1'b0;
        pending_items.push_back(it);
        pending_items.push_back(read_at(0, 0));
        pending_items.push_back(bare_op(OP_UNUSED));
        pending_items.push_back(bare_op(gfr_pkg::OP_CLEAR));
        pending_items.push_back(read_at(0, 0));
        wait_drained();

        // Smallest grid, one cell per degree, edges at the field extremes.
        set_grid(-11796480, 5898240, 16384, 16384, 10, 10);
        pending_items.push_back(aimed_scatter(9, 9, 16'sd5));
        pending_items.push_back(read_at(9, 9));
        pending_items.push_back(read_at(9, 8));
        pending_items.push_back(read_at(10, 5));
        pending_items.push_back(aimed_scatter(4, 3, -16'sd7));
        pending_items.push_back(aimed_scatter(4, 5, 16'sd0));
        pending_items.push_back(aimed_scatter(3, 4, 16'sd0));
        pending_items.push_back(aimed_scatter(5, 4, 16'sd0));
        pending_items.push_back(read_at(4, 4));
        pending_items.push_back(aimed_scatter(12, 2, 16'sd9));
        it = aimed_scatter(0, 0, 16'sd3);
        it.lon = -25'sd11796480;
        pending_items.push_back(it);
        pending_items.push_back(read_at(0, 0));
        queue_random_items(85);
        wait_drained();

        set_grid(11796480, -5898240, 16777215, 16777215, 512, 512);
        queue_random_items(85);
        wait_drained();

        set_grid(0, 0, 300000, 500000, 20, 16);
        queue_random_items(85);
        wait_drained();

        set_grid(longint'($urandom_range(0, 2000000)) - 1000000,
                 longint'($urandom_range(0, 2000000)) - 1000000,
                 $urandom_range(1000, 200000), $urandom_range(1000, 200000),
                 $urandom_range(10, 40), $urandom_range(10, 40));
        queue_random_items(85);
        wait_drained();

        set_grid(-6553600, 3276800, 32768, 49152, 512, 512);
        queue_random_items(85);
        wait_drained();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit: covers several full tag sweeps at the largest grid.
    initial begin
        #30ms;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
